// File: hw/rtl/ptq_pkg.sv
// Shared types and codes for the pitch table quantizer.
// No dependencies; every other file imports this package.
`default_nettype none

package ptq_pkg;

    localparam int PITCH_W = 21;
    localparam int INDEX_W = 7;

    typedef logic signed [PITCH_W-1:0] t_pitch;
    typedef logic        [PITCH_W-1:0] t_dist;
    typedef logic        [INDEX_W-1:0] t_index;

    localparam logic CMD_WRITE    = 1'b0;
    localparam logic CMD_QUERY    = 1'b1;
    localparam logic MODE_FLOOR   = 1'b0;
    localparam logic MODE_NEAREST = 1'b1;

    // Search state carried from cell to cell along the chain.
    typedef struct packed {
        logic   mode;
        t_pitch query;
        t_dist  gap;
        t_pitch best;
        t_index index;
        logic   found;
    } t_token;

endpackage

`default_nettype wire

// File: hw/rtl/ptq_ifs.sv
// Valid/ready channel interfaces for the pitch table quantizer.
// Depends on ptq_pkg for payload types.
`default_nettype none

interface ptq_req_if;
    import ptq_pkg::*;
    logic   valid;
    logic   ready;
    logic   cmd;
    t_index note_index;
    t_pitch pitch_value;
    modport source (output valid, cmd, note_index, pitch_value, input ready);
    modport sink   (input valid, cmd, note_index, pitch_value, output ready);
endinterface

interface ptq_res_if;
    import ptq_pkg::*;
    logic   valid;
    logic   ready;
    t_pitch quantized_pitch;
    t_index chosen_index;
    logic   found;
    modport source (output valid, quantized_pitch, chosen_index, found, input ready);
    modport sink   (input valid, quantized_pitch, chosen_index, found, output ready);
endinterface

interface ptq_cfg_if;
    logic valid;
    logic ready;
    logic quantize_mode;
    modport source (output valid, quantize_mode, input ready);
    modport sink   (input valid, quantize_mode, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ptq_cell.sv
// One cell of the search chain: holds one table entry and compares it
// against the passing search item. Depends on ptq_pkg.
`default_nettype none

module ptq_cell #(
    parameter int IDX = 0
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_adv,
    input  wire               i_wr_en,
    input  ptq_pkg::t_index   i_wr_index,
    input  ptq_pkg::t_pitch   i_wr_pitch,
    input  wire               i_valid,
    input  ptq_pkg::t_token   i_tok,
    output logic              o_valid,
    output ptq_pkg::t_token   o_tok
);
    import ptq_pkg::*;

    localparam bit FIRST    = (IDX == 0);
    localparam bit WR_REACH = (IDX < (2 ** INDEX_W));

    t_pitch            r_entry;
    logic              r_valid;
    t_token            r_tok;
    t_token            n_tok;
    logic signed [PITCH_W:0] w_diff;
    t_dist             w_dist;
    logic              w_take;

    always_comb begin
        w_diff = $signed({r_entry[PITCH_W-1], r_entry})
               - $signed({i_tok.query[PITCH_W-1], i_tok.query});
        w_dist = w_diff[PITCH_W] ? PITCH_W'(-w_diff) : w_diff[PITCH_W-1:0];
        if (i_tok.mode == MODE_NEAREST) begin
            w_take = FIRST || (w_dist <= i_tok.gap);
        end else begin
            w_take = !FIRST && ($signed(r_entry) <= $signed(i_tok.query));
        end
        n_tok = i_tok;
        if (w_take) begin
            n_tok.gap   = w_dist;
            n_tok.best  = r_entry;
            n_tok.index = t_index'(IDX);
            n_tok.found = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
            r_valid <= 1'b0;
        end else begin
            if (WR_REACH && i_wr_en && (i_wr_index == t_index'(IDX))) begin
                r_entry <= i_wr_pitch;
            end
            if (i_adv) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;

endmodule

`default_nettype wire

// File: hw/rtl/pitch_table_quantizer_unit.sv
// Pitch table quantizer: a row of cells, one per table entry, that a
// query walks through. Depends on ptq_pkg, ptq_ifs and ptq_cell.
//
// A write item stores one pitch and returns nothing. A query item enters
// the first cell and moves one cell per clock while the row is not
// stalled by an untaken result, each cell comparing its own entry; the
// result comes from the last cell. One query is in the row at a time,
// and input ready stays low until it has left the row. The finished
// result waits in an output register, so a new item is taken while the
// result is still pending. The table and the mode register are cleared
// by reset with no extra pass.
`default_nettype none

module pitch_table_quantizer_unit #(
    parameter int NUM_NOTES = 128
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ptq_req_if.sink    i_req,
    ptq_res_if.source  o_res,
    ptq_cfg_if.sink    i_cfg
);
    import ptq_pkg::*;

    logic               r_mode;
    logic               r_busy;
    logic               r_out_valid;
    t_pitch             r_out_pitch;
    t_index             r_out_index;
    logic               r_out_found;

    logic [NUM_NOTES:0] w_valid;
    t_token             w_tok [NUM_NOTES+1];
    logic               w_adv;
    logic               w_in_acc;
    logic               w_done;

    assign w_in_acc = i_req.valid && i_req.ready;
    assign w_adv    = !(w_valid[NUM_NOTES] && r_out_valid && !o_res.ready);
    assign w_done   = w_valid[NUM_NOTES] && w_adv;

    assign w_valid[0] = w_in_acc && (i_req.cmd == CMD_QUERY);
    always_comb begin
        w_tok[0].mode  = r_mode;
        w_tok[0].query = i_req.pitch_value;
        w_tok[0].gap   = '0;
        w_tok[0].best  = '0;
        w_tok[0].index = '0;
        w_tok[0].found = 1'b0;
    end

    for (genvar g = 0; g < NUM_NOTES; g++) begin : g_cell
        ptq_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (w_adv),
            .i_wr_en    (w_in_acc && (i_req.cmd == CMD_WRITE)),
            .i_wr_index (i_req.note_index),
            .i_wr_pitch (i_req.pitch_value),
            .i_valid    (w_valid[g]),
            .i_tok      (w_tok[g]),
            .o_valid    (w_valid[g+1]),
            .o_tok      (w_tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_FLOOR;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_mode <= i_cfg.quantize_mode;
            end
            if (w_valid[0]) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_pitch <= w_tok[NUM_NOTES].best;
            r_out_index <= w_tok[NUM_NOTES].index;
            r_out_found <= w_tok[NUM_NOTES].found;
        end
    end

    assign i_req.ready           = !r_busy;
    assign i_cfg.ready           = 1'b1;
    assign o_res.valid           = r_out_valid;
    assign o_res.quantized_pitch = r_out_pitch;
    assign o_res.chosen_index    = r_out_index;
    assign o_res.found           = r_out_found;

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[0] |=> r_busy)
        else $error("query accepted without marking busy");

    a_one_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid[NUM_NOTES:1]) <= 1)
        else $error("more than one query in the cell row");

    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[NUM_NOTES] |-> r_busy)
        else $error("query left the row while not busy");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.found) |->
            (o_res.chosen_index == '0 && o_res.quantized_pitch == '0))
        else $error("result without match is not zero");

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking bench for pitch_table_quantizer_unit: table writes, floor and
// nearest snapping, mode changes between phases, random stalls on both sides.
// Depends on ptq_pkg, ptq_ifs and the quantizer RTL.
`timescale 1ns / 1ps

module tb;
    import ptq_pkg::*;

    localparam int NUM_NOTES   = 128;
    localparam int SETTLE      = NUM_NOTES + 8;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 75;
    localparam int CYCLE_LIMIT = 600000;

    localparam t_pitch PITCH_MAX = {1'b0, {(PITCH_W-1){1'b1}}};
    localparam t_pitch PITCH_MIN = {1'b1, {(PITCH_W-1){1'b0}}};

    typedef struct packed {
        t_pitch pitch;
        t_index index;
        logic   found;
    } t_snap;

    typedef struct packed {
        logic   mode;
        logic   cmd;
        t_index index;
        t_pitch pitch;
        logic   typed;
        t_snap  snap;
    } t_dir_row;

    localparam int DIR_ROWS = 22;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{MODE_FLOOR,   CMD_QUERY, 7'd0,   21'sd0,          1'b1, '{21'sd0, 7'd127, 1'b1}},
        '{MODE_FLOOR,   CMD_QUERY, 7'd0,   -21'sd1,         1'b1, '{21'sd0, 7'd0,   1'b0}},
        '{MODE_FLOOR,   CMD_QUERY, 7'd0,   PITCH_MAX,       1'b1, '{21'sd0, 7'd127, 1'b1}},
        '{MODE_FLOOR,   CMD_QUERY, 7'd127, PITCH_MIN,       1'b1, '{21'sd0, 7'd0,   1'b0}},
        '{MODE_FLOOR,   CMD_WRITE, 7'd127, PITCH_MAX,       1'b0, '0},
        '{MODE_FLOOR,   CMD_QUERY, 7'd0,   PITCH_MAX - 21'sd1, 1'b0, '0},
        '{MODE_FLOOR,   CMD_QUERY, 7'd0,   PITCH_MAX,       1'b1, '{PITCH_MAX, 7'd127, 1'b1}},
        '{MODE_FLOOR,   CMD_WRITE, 7'd5,   PITCH_MIN,       1'b0, '0},
        '{MODE_FLOOR,   CMD_QUERY, 7'd0,   PITCH_MIN,       1'b0, '0},
        '{MODE_FLOOR,   CMD_WRITE, 7'd0,   -21'sd524288,    1'b0, '0},
        '{MODE_FLOOR,   CMD_QUERY, 7'd0,   -21'sd600000,    1'b0, '0},
        '{MODE_NEAREST, CMD_QUERY, 7'd0,   21'sd0,          1'b0, '0},
        '{MODE_NEAREST, CMD_QUERY, 7'd0,   PITCH_MAX,       1'b0, '0},
        '{MODE_NEAREST, CMD_QUERY, 7'd0,   PITCH_MIN,       1'b0, '0},
        '{MODE_NEAREST, CMD_QUERY, 7'd0,   -21'sd700000,    1'b0, '0},
        '{MODE_NEAREST, CMD_WRITE, 7'd64,  21'sd200,        1'b0, '0},
        '{MODE_NEAREST, CMD_QUERY, 7'd0,   21'sd100,        1'b0, '0},
        '{MODE_NEAREST, CMD_QUERY, 7'd0,   21'sd150,        1'b0, '0},
        '{MODE_FLOOR,   CMD_QUERY, 7'd0,   -21'sd1,         1'b0, '0},
        '{MODE_FLOOR,   CMD_WRITE, 7'd5,   21'sd0,          1'b0, '0},
        '{MODE_FLOOR,   CMD_QUERY, 7'd0,   -21'sd1,         1'b1, '{21'sd0, 7'd0,   1'b0}},
        '{MODE_FLOOR,   CMD_QUERY, 7'd0,   21'sd199,        1'b0, '0}
    };

    logic clk;
    logic rst_n;

    ptq_req_if req_bus ();
    ptq_res_if res_bus ();
    ptq_cfg_if cfg_bus ();

    pitch_table_quantizer_unit #(
        .NUM_NOTES(NUM_NOTES)
    ) i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_bus),
        .o_res  (res_bus),
        .i_cfg  (cfg_bus)
    );

    t_pitch note_tab [NUM_NOTES];
    logic   snap_mode;
    t_snap  pending_snaps [$];
    int     mismatches;
    int     cycle_count;
    bit     quiet;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic t_snap snap_pitch(t_pitch q);
        t_snap  r;
        longint d;
        longint best;
        r    = '0;
        best = -1;
        if (snap_mode == MODE_FLOOR) begin
            for (int i = NUM_NOTES - 1; i > 0; i--) begin
                if (note_tab[i] <= q) begin
                    r = '{note_tab[i], t_index'(i), 1'b1};
                    break;
                end
            end
        end else begin
            for (int i = 0; i < NUM_NOTES; i++) begin
                d = longint'(note_tab[i]) - longint'(q);
                if (d < 0)
                    d = -d;
                if (best < 0 || d <= best) begin
                    best = d;
                    r    = '{note_tab[i], t_index'(i), 1'b1};
                end
            end
        end
        return r;
    endfunction

    function automatic t_pitch rand_pitch();
        int unsigned a;
        int unsigned b;
        longint      mid;
        a = $urandom_range(0, NUM_NOTES - 1);
        b = $urandom_range(0, NUM_NOTES - 1);
        case ($urandom_range(0, 6))
            0, 1: return t_pitch'($urandom);
            2: return t_pitch'($urandom_range(0, 512)) - t_pitch'(256);
            3: begin
                case ($urandom_range(0, 3))
                    0: return PITCH_MAX;
                    1: return PITCH_MIN;
                    2: return PITCH_MAX - t_pitch'(1);
                    default: return PITCH_MIN + t_pitch'(1);
                endcase
            end
            4, 5: return note_tab[a] + t_pitch'($urandom_range(0, 4)) - t_pitch'(2);
            default: begin
                mid = (longint'(note_tab[a]) + longint'(note_tab[b])) / 2;
                return t_pitch'(mid);
            end
        endcase
    endfunction

    task automatic send_item(logic cmd, t_index idx, t_pitch pitch, logic typed, t_snap want);
        @(negedge clk);
        req_bus.valid       <= 1'b1;
        req_bus.cmd         <= cmd;
        req_bus.note_index  <= idx;
        req_bus.pitch_value <= pitch;
        do @(posedge clk); while (!req_bus.ready);
        if (cmd == CMD_WRITE)
            note_tab[idx] = pitch;
        else
            pending_snaps.push_back(typed ? want : snap_pitch(pitch));
    endtask

    task automatic write_mode(logic mode);
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (pending_snaps.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_bus.valid         <= 1'b1;
        cfg_bus.quantize_mode <= mode;
        do @(posedge clk); while (!cfg_bus.ready);
        snap_mode = mode;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // sink side: random stall bursts, none once quiet
    initial begin
        int stall_left;
        stall_left    = 0;
        res_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (quiet) begin
                res_bus.ready <= 1'b1;
            end else if (stall_left > 0) begin
                res_bus.ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 5) == 0) begin
                res_bus.ready <= 1'b0;
                stall_left = $urandom_range(1, 12) - 1;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        t_snap got;
        t_snap want;
        if (rst_n && res_bus.valid && res_bus.ready) begin
            got = '{res_bus.quantized_pitch, res_bus.chosen_index, res_bus.found};
            if (pending_snaps.size() == 0) begin
                $error("unexpected result: quantized_pitch %0d chosen_index %0d found %0b",
                       got.pitch, got.index, got.found);
                mismatches++;
            end else begin
                want = pending_snaps.pop_front();
                if (got.pitch !== want.pitch) begin
                    $error("quantized_pitch: expected %0d, got %0d", want.pitch, got.pitch);
                    mismatches++;
                end
                if (got.index !== want.index) begin
                    $error("chosen_index: expected %0d, got %0d", want.index, got.index);
                    mismatches++;
                end
                if (got.found !== want.found) begin
                    $error("found: expected %0b, got %0b", want.found, got.found);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic   cmd;
        t_index idx;
        int     gap_odds;
        rst_n                 = 1'b0;
        req_bus.valid         = 1'b0;
        req_bus.cmd           = CMD_WRITE;
        req_bus.note_index    = '0;
        req_bus.pitch_value   = '0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.quantize_mode = MODE_FLOOR;
        snap_mode             = MODE_FLOOR;
        mismatches            = 0;
        cycle_count           = 0;
        quiet                 = 1'b0;
        for (int i = 0; i < NUM_NOTES; i++)
            note_tab[i] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_mode(MODE_FLOOR);
        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].mode != snap_mode)
                write_mode(DIRECTED[r].mode);
            send_item(DIRECTED[r].cmd, DIRECTED[r].index, DIRECTED[r].pitch,
                      DIRECTED[r].typed, DIRECTED[r].snap);
        end

        for (int p = 0; p < PHASES; p++) begin
            write_mode(p < 2 ? logic'(p[0]) : logic'($urandom_range(0, 1)));
            quiet = (p == PHASES - 1);
            gap_odds = $urandom_range(0, 1) ? 4 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 20 == 0 && p != PHASES - 1)
                    gap_odds = $urandom_range(0, 2) == 0 ? 0 : 4;
                if (!quiet && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
                    repeat ($urandom_range(1, 12)) begin
                        @(negedge clk);
                        req_bus.valid <= 1'b0;
                    end
                end
                cmd = ($urandom_range(0, 99) < 55) ? CMD_WRITE : CMD_QUERY;
                idx = t_index'($urandom_range(0, NUM_NOTES - 1));
                send_item(cmd, idx, rand_pitch(), 1'b0, '0);
            end
        end

        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (pending_snaps.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/ptq_pkg.sv
hw/rtl/ptq_ifs.sv
hw/rtl/ptq_cell.sv
hw/rtl/pitch_table_quantizer_unit.sv
test/tb.sv
